>>> design/sra_pkg.sv
package sra_pkg;

   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_AVG      = 16;

   localparam int CH_W       = $clog2(MAX_CHANNELS);
   localparam int NCH_W      = 11;
   localparam int AVG_W      = 5;
   localparam int SAMPLE_W   = 32;
   localparam int QUANT_W    = 8;
   localparam int SUM_W      = 64;
   localparam int GSUM_W     = 12;
   localparam int PROD_W     = 16;
   localparam int DIV_W      = 32;
   localparam int DIV_CNT_W  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [NCH_W-1:0] NCH_MAX = NCH_W'(MAX_CHANNELS);
   localparam logic [AVG_W-1:0] AVG_MAX = AVG_W'(MAX_AVG);

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_FACTOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESCALE_ENABLE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH     = 3'd5;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_MEAN = 1'b1;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_QUANT = DIV_CNT_W'(QUANT_W);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_AVG   = DIV_CNT_W'(GSUM_W);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MEAN  = DIV_CNT_W'(DIV_W);

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] sample_value;
      logic [CH_W-1:0]     read_channel;
   } sra_req_type;

   typedef struct packed {
      logic                kind;
      logic [CH_W-1:0]     out_channel;
      logic [QUANT_W-1:0]  quant_value;
      logic                last_of_spectrum;
      logic [SAMPLE_W-1:0] mean_power;
      logic [SAMPLE_W-1:0] raw_min;
      logic [SAMPLE_W-1:0] raw_max;
   } sra_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_W-1:0]     hi;
      logic [DIV_W-1:0]     lo;
      logic [DIV_W-1:0]     divisor;
   } sra_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } sra_div_rsp_type;

   typedef struct packed {
      logic             rd_en;
      logic [CH_W-1:0]  rd_addr;
      logic             wr_en;
      logic [CH_W-1:0]  wr_addr;
      logic [SUM_W-1:0] wr_data;
   } sra_mem_req_type;

endpackage

>>> design/sra_div.sv
module sra_div import sra_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sra_div_req_type div_req,
   output sra_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     low_ff, low_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_W:0]       rem_shift;
   logic [DIV_W:0]       rem_diff;

   assign rem_shift = {rem_ff, low_ff[DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = div_req.steps;
         rem_in     = div_req.hi;
         low_in     = div_req.lo;
         quo_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         low_in = {low_ff[DIV_W-2:0], 1'b0};
         if (!rem_diff[DIV_W]) begin
            rem_in = rem_diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> design/sra_power_ram.sv
module sra_power_ram import sra_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  sra_mem_req_type  mem_req,
   output logic [SUM_W-1:0] rd_data
);

   logic [SUM_W-1:0] mem [MAX_CHANNELS];
   logic [SUM_W-1:0] rd_word_ff;
   logic             rd_hit_ff;
   logic [NCH_W-1:0] fill_ff, fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (mem_req.wr_en && ({1'b0, mem_req.wr_addr} == fill_ff)) begin
         fill_in = fill_ff + NCH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_word_ff <= mem[mem_req.rd_addr];
         rd_hit_ff  <= ({1'b0, mem_req.rd_addr} < fill_ff);
      end
   end

   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

>>> design/spectrum_requantize_average_unit.sv
// Requantizes one spectrometer channel sample per transaction to a byte, averages
// groups of avg_factor bytes and keeps a 64-bit power sum per channel in a
// 1024-entry RAM with separate read and write ports; a fill count marks the
// entries written since reset, so the block is ready straight out of reset with
// no clearing pass. Items are handled one at a time by a sequencer around the RAM
// and a shared divider that produces one quotient bit per cycle. A sample passes
// through read, quantize and accumulate states, plus the 8-step division when the
// linear range mapping needs it and, when it completes an output byte, the 12-step
// group average and the output load. A mean power read runs the 32-step division
// of the sum by the timestep count when needed. A result waiting in the output
// register delays only the next item that also produces one.
module spectrum_requantize_average_unit import sra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sra_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sra_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SAMP_RD  = 9'b000000010,
      ST_SAMP_Q   = 9'b000000100,
      ST_SAMP_DIV = 9'b000001000,
      ST_SAMP_ACC = 9'b000010000,
      ST_SAMP_AVG = 9'b000100000,
      ST_READ_RD  = 9'b001000000,
      ST_READ_DIV = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [NCH_W-1:0]    nch_cfg_ff;
   logic [AVG_W-1:0]    avg_cfg_ff;
   logic                rescale_ff;
   logic                range_set_ff;
   logic [SAMPLE_W-1:0] range_low_ff;
   logic [SAMPLE_W-1:0] range_high_ff;

   logic [CH_W-1:0]     in_ch_ff, in_ch_in;
   logic [CH_W-1:0]     out_idx_ff, out_idx_in;
   logic [GSUM_W-1:0]   gsum_ff, gsum_in;
   logic [AVG_W-1:0]    gcnt_ff, gcnt_in;
   logic [SAMPLE_W-1:0] ts_ff, ts_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;

   logic [SAMPLE_W-1:0] v_ff, v_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [SAMPLE_W-1:0] d_ff, d_in;
   logic [SAMPLE_W+7:0] n_ff, n_in;
   logic [SAMPLE_W-1:0] r_ff, r_in;
   logic [QUANT_W-1:0]  q_ff, q_in;

   logic                res_kind_ff, res_kind_in;
   logic [CH_W-1:0]     res_ch_ff, res_ch_in;
   logic [QUANT_W-1:0]  res_quant_ff, res_quant_in;
   logic                res_last_ff, res_last_in;
   logic [SAMPLE_W-1:0] res_mean_ff, res_mean_in;

   logic                rsp_valid_ff, rsp_valid_in;
   sra_rsp_type         rsp_data_ff, rsp_data_in;

   logic [NCH_W-1:0]    nch_eff;
   logic [AVG_W-1:0]    avg_eff;
   logic [NCH_W-1:0]    ch_clamp;
   logic                scale_on;
   logic [SUM_W-1:0]    mem_rd_data;
   logic [GSUM_W-1:0]   gsum_new;
   logic [AVG_W-1:0]    gcnt_new;
   logic                grp_done;
   logic [PROD_W-1:0]   prod1;
   logic                emit;
   logic                last_grp;
   logic                spec_end;

   sra_mem_req_type     mem_req;
   sra_div_req_type     div_req;
   sra_div_rsp_type     div_rsp;

   sra_power_ram u_power_ram (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   sra_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nch_cfg_ff    <= NCH_MAX;
         avg_cfg_ff    <= AVG_W'(1);
         rescale_ff    <= 1'b0;
         range_set_ff  <= 1'b0;
         range_low_ff  <= '0;
         range_high_ff <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_CHANNELS:   nch_cfg_ff    <= csr_wdata[NCH_W-1:0];
            CSR_AVG_FACTOR:     avg_cfg_ff    <= csr_wdata[AVG_W-1:0];
            CSR_RESCALE_ENABLE: rescale_ff    <= csr_wdata[0];
            CSR_RANGE_SET:      range_set_ff  <= csr_wdata[0];
            CSR_RANGE_LOW:      range_low_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_RANGE_HIGH:     range_high_ff <= csr_wdata[SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign nch_eff = (nch_cfg_ff == '0) ? NCH_W'(1) :
                    (nch_cfg_ff > NCH_MAX) ? NCH_MAX : nch_cfg_ff;
   assign avg_eff = (avg_cfg_ff == '0) ? AVG_W'(1) :
                    (avg_cfg_ff > AVG_MAX) ? AVG_MAX : avg_cfg_ff;
   assign ch_clamp = ({1'b0, in_ch_ff} >= nch_eff) ? (nch_eff - NCH_W'(1)) :
                     {1'b0, in_ch_ff};
   assign scale_on = rescale_ff && range_set_ff;

   assign gsum_new = gsum_ff + GSUM_W'(q_ff);
   assign gcnt_new = gcnt_ff + AVG_W'(1);
   assign grp_done = (gcnt_new >= avg_eff);
   assign prod1    = PROD_W'({1'b0, out_idx_ff} + NCH_W'(1)) * PROD_W'(avg_eff);
   assign emit     = grp_done && (prod1 <= PROD_W'(nch_eff));
   assign last_grp = (prod1 + PROD_W'(avg_eff)) > PROD_W'(nch_eff);
   assign spec_end = ({1'b0, ch_ff} + NCH_W'(1)) >= nch_eff;

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in     = state_ff;
      in_ch_in     = in_ch_ff;
      out_idx_in   = out_idx_ff;
      gsum_in      = gsum_ff;
      gcnt_in      = gcnt_ff;
      ts_in        = ts_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      v_in         = v_ff;
      ch_in        = ch_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      res_kind_in  = res_kind_ff;
      res_ch_in    = res_ch_ff;
      res_quant_in = res_quant_ff;
      res_last_in  = res_last_ff;
      res_mean_in  = res_mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               v_in = req_data.sample_value;
               d_in = req_data.sample_value - range_low_ff;
               if (req_data.cmd == CMD_READ) begin
                  ch_in    = req_data.read_channel;
                  state_in = ST_READ_RD;
               end else begin
                  ch_in    = ch_clamp[CH_W-1:0];
                  state_in = ST_SAMP_RD;
               end
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ch_in;
            end
         end

         ST_SAMP_RD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ch_ff;
            mem_req.wr_data = mem_rd_data + SUM_W'(v_ff);
            if (v_ff < min_ff) begin
               min_in = v_ff;
            end
            if (v_ff > max_ff) begin
               max_in = v_ff;
            end
            n_in     = {d_ff, 8'b0} - {8'b0, d_ff};
            r_in     = range_high_ff - range_low_ff;
            state_in = ST_SAMP_Q;
         end

         ST_SAMP_Q: begin
            state_in = ST_SAMP_ACC;
            if (!scale_on) begin
               q_in = (v_ff > SAMPLE_W'(255)) ? '1 : v_ff[QUANT_W-1:0];
            end else if (range_high_ff <= range_low_ff) begin
               q_in = (v_ff > range_low_ff) ? '1 : '0;
            end else if (v_ff <= range_low_ff) begin
               q_in = '0;
            end else if (n_ff >= {r_ff, 8'b0}) begin
               q_in = '1;
            end else begin
               div_req.start   = 1'b1;
               div_req.steps   = DIV_STEPS_QUANT;
               div_req.hi      = n_ff[SAMPLE_W+7:8];
               div_req.lo      = {n_ff[7:0], 24'b0};
               div_req.divisor = r_ff;
               state_in        = ST_SAMP_DIV;
            end
         end

         ST_SAMP_DIV: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quotient[QUANT_W-1:0];
               state_in = ST_SAMP_ACC;
            end
         end

         ST_SAMP_ACC: begin
            if (grp_done) begin
               gsum_in = '0;
               gcnt_in = '0;
            end else begin
               gsum_in = gsum_new;
               gcnt_in = gcnt_new;
            end
            if (emit) begin
               out_idx_in      = out_idx_ff + CH_W'(1);
               res_kind_in     = KIND_BYTE;
               res_ch_in       = out_idx_ff;
               res_last_in     = last_grp;
               res_mean_in     = '0;
               div_req.start   = 1'b1;
               div_req.steps   = DIV_STEPS_AVG;
               div_req.hi      = '0;
               div_req.lo      = {gsum_new, 20'b0};
               div_req.divisor = DIV_W'(gcnt_new);
               state_in        = ST_SAMP_AVG;
            end else begin
               state_in = ST_IDLE;
            end
            if (spec_end) begin
               in_ch_in   = '0;
               out_idx_in = '0;
               gsum_in    = '0;
               gcnt_in    = '0;
               ts_in      = ts_ff + SAMPLE_W'(1);
            end else begin
               in_ch_in = ch_ff + CH_W'(1);
            end
         end

         ST_SAMP_AVG: begin
            if (div_rsp.done) begin
               res_quant_in = div_rsp.quotient[QUANT_W-1:0];
               state_in     = ST_DONE;
            end
         end

         ST_READ_RD: begin
            res_kind_in  = KIND_MEAN;
            res_ch_in    = ch_ff;
            res_quant_in = '0;
            res_last_in  = 1'b0;
            state_in     = ST_DONE;
            if (ts_ff == '0) begin
               res_mean_in = '0;
            end else if (mem_rd_data[SUM_W-1:DIV_W] >= ts_ff) begin
               res_mean_in = '1;
            end else begin
               div_req.start   = 1'b1;
               div_req.steps   = DIV_STEPS_MEAN;
               div_req.hi      = mem_rd_data[SUM_W-1:DIV_W];
               div_req.lo      = mem_rd_data[DIV_W-1:0];
               div_req.divisor = ts_ff;
               state_in        = ST_READ_DIV;
            end
         end

         ST_READ_DIV: begin
            if (div_rsp.done) begin
               res_mean_in = div_rsp.quotient;
               state_in    = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.kind             = res_kind_ff;
               rsp_data_in.out_channel      = res_ch_ff;
               rsp_data_in.quant_value      = res_quant_ff;
               rsp_data_in.last_of_spectrum = res_last_ff;
               rsp_data_in.mean_power       = res_mean_ff;
               rsp_data_in.raw_min          = min_ff;
               rsp_data_in.raw_max          = max_ff;
               state_in                     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_ch_ff     <= '0;
         out_idx_ff   <= '0;
         gsum_ff      <= '0;
         gcnt_ff      <= '0;
         ts_ff        <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_ch_ff     <= in_ch_in;
         out_idx_ff   <= out_idx_in;
         gsum_ff      <= gsum_in;
         gcnt_ff      <= gcnt_in;
         ts_ff        <= ts_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      ch_ff        <= ch_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      res_kind_ff  <= res_kind_in;
      res_ch_ff    <= res_ch_in;
      res_quant_ff <= res_quant_in;
      res_last_ff  <= res_last_in;
      res_mean_ff  <= res_mean_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/sra_checker.sv
module sra_checker import sra_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input sra_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction dropped or changed while stalled");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous transaction still in progress");

   a_mean_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_MEAN) |->
         (rsp_data.quant_value == '0) && !rsp_data.last_of_spectrum)
      else $error("readout carries byte fields");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_BYTE) |->
         (rsp_data.mean_power == '0) && (rsp_data.raw_min <= rsp_data.raw_max))
      else $error("byte result carries bad power or extremes");

endmodule

bind spectrum_requantize_average_unit sra_checker u_sra_checker (.*);

>>> tb/tb.sv
module tb;
   import sra_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          SETTLE_CYCLES = 64;
   localparam int          REPORT_CAP = 40;

   class requant_scoreboard;
      logic [NCH_W-1:0]    num_ch;
      logic [AVG_W-1:0]    avg_cfg;
      logic                rescale_on;
      logic                range_valid;
      logic [SAMPLE_W-1:0] rng_lo;
      logic [SAMPLE_W-1:0] rng_hi;

      int unsigned         in_ch;
      int unsigned         out_idx;
      int unsigned         grp_sum;
      int unsigned         grp_cnt;
      logic [31:0]         steps_done;
      logic [SAMPLE_W-1:0] min_v;
      logic [SAMPLE_W-1:0] max_v;
      logic [SUM_W-1:0]    chan_power [MAX_CHANNELS];

      sra_rsp_type         awaited_rsp [$];
      int                  errors;

      function new();
         num_ch      = NCH_W'(1024);
         avg_cfg     = AVG_W'(1);
         rescale_on  = 1'b0;
         range_valid = 1'b0;
         rng_lo      = '0;
         rng_hi      = '1;
         in_ch       = 0;
         out_idx     = 0;
         grp_sum     = 0;
         grp_cnt     = 0;
         steps_done  = '0;
         min_v       = '1;
         max_v       = '0;
         errors      = 0;
         foreach (chan_power[i]) chan_power[i] = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_NUM_CHANNELS:   num_ch      = val[NCH_W-1:0];
            CSR_AVG_FACTOR:     avg_cfg     = val[AVG_W-1:0];
            CSR_RESCALE_ENABLE: rescale_on  = val[0];
            CSR_RANGE_SET:      range_valid = val[0];
            CSR_RANGE_LOW:      rng_lo      = val;
            CSR_RANGE_HIGH:     rng_hi      = val;
            default: ;
         endcase
      endfunction

      function int unsigned to_byte(logic [SAMPLE_W-1:0] v);
         logic [63:0] q;
         if (rescale_on && range_valid) begin
            if (rng_hi <= rng_lo) return (v > rng_lo) ? 255 : 0;
            if (v <= rng_lo) return 0;
            q = (64'(v - rng_lo) * 64'd255) / 64'(rng_hi - rng_lo);
            return (q > 64'd255) ? 255 : int'(q);
         end
         return (v > 32'd255) ? 255 : int'(v);
      endfunction

      function void note_request(sra_req_type item);
         int unsigned         nch;
         int unsigned         avg;
         int unsigned         last_out;
         logic [SAMPLE_W-1:0] v;
         logic [63:0]         mean;
         sra_rsp_type         r;
         nch = (num_ch == 0) ? 1 : (num_ch > NCH_MAX) ? MAX_CHANNELS : num_ch;
         avg = (avg_cfg == 0) ? 1 : (avg_cfg > AVG_MAX) ? MAX_AVG : avg_cfg;
         last_out = nch / avg;
         r = '0;
         if (item.cmd == CMD_READ) begin
            mean = '0;
            if (steps_done != 0) begin
               mean = chan_power[item.read_channel] / 64'(steps_done);
               if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
            end
            r.kind        = KIND_MEAN;
            r.out_channel = item.read_channel;
            r.mean_power  = mean[31:0];
            r.raw_min     = min_v;
            r.raw_max     = max_v;
            awaited_rsp.push_back(r);
            return;
         end
         v = item.sample_value;
         if (v < min_v) min_v = v;
         if (v > max_v) max_v = v;
         if (in_ch >= nch) in_ch = nch - 1;
         chan_power[in_ch] += 64'(v);
         grp_sum += to_byte(v);
         grp_cnt++;
         if (grp_cnt >= avg) begin
            if (out_idx < last_out) begin
               r.kind             = KIND_BYTE;
               r.out_channel      = CH_W'(out_idx);
               r.quant_value      = QUANT_W'(grp_sum / grp_cnt);
               r.last_of_spectrum = (out_idx + 1 == last_out);
               r.raw_min          = min_v;
               r.raw_max          = max_v;
               awaited_rsp.push_back(r);
               out_idx++;
            end
            grp_sum = 0;
            grp_cnt = 0;
         end
         if (in_ch + 1 >= nch) begin
            in_ch      = 0;
            out_idx    = 0;
            grp_sum    = 0;
            grp_cnt    = 0;
            steps_done = steps_done + 1;
         end else begin
            in_ch++;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(sra_rsp_type got);
         sra_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("out_channel", 32'(want.out_channel), 32'(got.out_channel));
         compare_field("quant_value", 32'(want.quant_value), 32'(got.quant_value));
         compare_field("last_of_spectrum", 32'(want.last_of_spectrum),
                       32'(got.last_of_spectrum));
         compare_field("mean_power", want.mean_power, got.mean_power);
         compare_field("raw_min", want.raw_min, got.raw_min);
         compare_field("raw_max", want.raw_max, got.raw_max);
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      function void drain_check();
         if (awaited_rsp.size() != 0) begin
            errors += awaited_rsp.size();
            $display("%0t: %0d transactions never arrived, expected %h, actual none",
                     $time, awaited_rsp.size(), awaited_rsp[0]);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sra_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sra_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   requant_scoreboard sb = new();

   int unsigned           cycle_count = 0;
   int                    items_sent = 0;
   int                    stall_left = 0;
   bit                    calm = 1'b0;
   logic [SAMPLE_W-1:0]   cur_lo = '0;
   logic [SAMPLE_W-1:0]   cur_hi = '1;
   int unsigned           cur_nch = MAX_CHANNELS;

   spectrum_requantize_average_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   function automatic sra_req_type make_req(logic cmd, logic [SAMPLE_W-1:0] v,
                                            logic [CH_W-1:0] ch);
      sra_req_type r;
      r.cmd          = cmd;
      r.sample_value = v;
      r.read_channel = ch;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(cur_lo, cur_hi);
         4:          return cur_lo - $urandom_range(0, 3);
         5:          return cur_hi + $urandom_range(0, 3);
         6:          return $urandom_range(0, 300);
         7:          return $urandom_range(0, 1) ? '1 : '0;
         default:    return $urandom;
      endcase
   endfunction

   task automatic send_item(input sra_req_type item);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic program_regs(input int unsigned nch, input int unsigned avg,
                               input logic rescale, input logic rset,
                               input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
      write_reg(CSR_NUM_CHANNELS, nch);
      write_reg(CSR_AVG_FACTOR, avg);
      write_reg(CSR_RESCALE_ENABLE, CSR_DATA_W'(rescale));
      write_reg(CSR_RANGE_SET, CSR_DATA_W'(rset));
      write_reg(CSR_RANGE_LOW, lo);
      write_reg(CSR_RANGE_HIGH, hi);
      csr_we  <= 1'b0;
      cur_lo  = lo;
      cur_hi  = hi;
      cur_nch = (nch == 0) ? 1 : (nch > MAX_CHANNELS) ? MAX_CHANNELS : nch;
   endtask

   // drain the block completely before touching the registers
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_settings();
      int unsigned         nch;
      int unsigned         avg;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      case ($urandom_range(0, 9))
         0:          nch = ($urandom_range(0, 1)) ? $urandom_range(0, 2) : $urandom_range(1024, 2047);
         7, 8:       nch = $urandom_range(25, 200);
         9:          nch = $urandom_range(0, 2047);
         default:    nch = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
         0:          avg = ($urandom_range(0, 1)) ? $urandom_range(0, 1) : $urandom_range(16, 31);
         7, 8, 9:    avg = $urandom_range(1, 16);
         default:    avg = $urandom_range(1, 4);
      endcase
      lo = $urandom;
      case ($urandom_range(0, 9))
         0:          begin lo = '0; hi = '1; end
         1:          hi = lo;
         2:          hi = $urandom;
         3, 4, 5:    hi = lo + $urandom_range(1, 600);
         6, 7:       hi = lo + $urandom_range(600, 1 << 20);
         default:    begin lo = $urandom_range(0, 1000); hi = lo + $urandom_range(1, 2000); end
      endcase
      program_regs(nch, avg, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, lo, hi);
   endtask

   initial begin
      sra_req_type item;
      int          n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(make_req(CMD_READ, 32'd0, 10'd0));
      send_item(make_req(CMD_READ, '1, 10'd1023));
      send_item(make_req(CMD_SAMPLE, 32'd0, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd255, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd256, 10'd0));
      send_item(make_req(CMD_SAMPLE, '1, '1));
      send_item(make_req(CMD_SAMPLE, 32'd1, 10'd0));
      send_item(make_req(CMD_READ, 32'd0, 10'd3));
      finish_phase();

      program_regs(0, 0, 1'b1, 1'b1, 32'd100, 32'd355);
      send_item(make_req(CMD_SAMPLE, 32'd50, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd100, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd101, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd355, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd1000, 10'd0));
      send_item(make_req(CMD_READ, 32'd0, 10'd0));
      finish_phase();

      program_regs(1, 1, 1'b1, 1'b1, 32'd100, 32'd100);
      send_item(make_req(CMD_SAMPLE, 32'd100, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd101, 10'd0));
      finish_phase();
      program_regs(1, 1, 1'b1, 1'b1, '1, '0);
      send_item(make_req(CMD_SAMPLE, '1, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd0, 10'd0));
      finish_phase();

      program_regs(3, 5, 1'b0, 1'b1, 32'd0, 32'd255);
      send_item(make_req(CMD_SAMPLE, 32'd300, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd2, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd3, 10'd0));
      finish_phase();

      program_regs(2047, 31, 1'b1, 1'b0, 32'd0, 32'd1000);
      send_item(make_req(CMD_SAMPLE, 32'd500, 10'd0));
      send_item(make_req(CMD_SAMPLE, 32'd600, 10'd0));
      send_item(make_req(CMD_READ, 32'd0, 10'd1));
      finish_phase();
      program_regs(2047, 2, 1'b0, 1'b0, 32'd0, 32'd1000);
      send_item(make_req(CMD_SAMPLE, 32'd7, 10'd0));
      finish_phase();

      while (items_sent < 1100) begin
         pick_settings();
         calm = ($urandom_range(0, 3) == 0);
         n = $urandom_range(30, 120);
         repeat (n) begin
            item.cmd = ($urandom_range(0, 99) < 15) ? CMD_READ : CMD_SAMPLE;
            item.sample_value = pick_sample();
            item.read_channel = ($urandom_range(0, 9) < 7) ? CH_W'($urandom_range(0, cur_nch - 1))
                                                           : CH_W'($urandom);
            send_item(item);
         end
         finish_phase();
      end

      sb.drain_check();
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
